// ----- src/hfps_pkg.sv -----
// hfps_pkg: widths, result codes and series constants for the windowed FFT
// power spectrum block. No dependencies.
`timescale 1ns / 1ps

package hfps_pkg;

    localparam int SMP_W   = 16;
    localparam int BIN_W   = 10;
    localparam int STORE_W = 27;
    localparam int POWER_W = 51;
    localparam int ERR_W   = 2;
    localparam int ROM_W   = 17;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
    localparam logic signed [STORE_W-1:0] STORE_MAX = {1'b0, {(STORE_W-1){1'b1}}};
    localparam logic signed [STORE_W-1:0] STORE_MIN = {1'b1, {(STORE_W-1){1'b0}}};

    // Q30 constants for the ROM series
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // Taylor term divisors: (2n-1)(2n) for cosine, (2n)(2n+1) for sine
    localparam longint unsigned C_COS_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned C_SIN_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    // floor((v + 2^(k-1)) / 2^k)
    function automatic longint round_shift(input longint v, input int k);
        longint t;
        t = v + (64'sd1 <<< (k - 1));
        return t >>> k;
    endfunction

endpackage

// ----- src/hann_fft_power_spectrum.sv -----
// hann_fft_power_spectrum: Hann-windowed radix-2 DIT FFT with power readout.
// Uses hfps_pkg. Window and twiddle ROMs are built at elaboration.
//
// channel   dir  handshake               payload
// s_axis    in   i_s_tvalid/o_s_tready   tdata{bin,sample} tuser=mode tlast=last
// m_axis    out  o_m_tvalid/i_m_tready   tdata{error,power}
//
// Load: each sample passes window ROM read, shared multiplier, store write.
// Last load: zero fill to N, then (N/2)*log2(N) butterflies, each through
// BAD, BRD, BM0-BM4, BWA, BWB, as the single multiplier does 4 products per
// butterfly and the sample memory has a single write port. Read: a bad bin
// or empty spectrum goes straight to RSUM, a good bin via RRD, RM0, RM1; RSUM
// holds while the previous result waits. Loads are taken while a result waits.
// Reset clears control state only; sample memory contents are don't-care.
`timescale 1ns / 1ps

module hann_fft_power_spectrum
    import hfps_pkg::*;
#(
    parameter int FFT_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] sample, [25:16] bin, rest zero
    input  logic        i_s_tuser,   // mode: 0 load, 1 read
    input  logic        i_s_tlast,   // last sample of frame
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [50:0] power, [52:51] error, rest zero
);

    localparam int  AW   = $clog2(FFT_SIZE);
    localparam int  SW   = $clog2(AW);
    localparam int  DW   = 2 * STORE_W;
    localparam int  PW   = 2 * STORE_W;
    localparam longint NWIN = FFT_SIZE - 1;
    localparam longint NTW  = FFT_SIZE;
    localparam int  HALF = FFT_SIZE / 2;

    typedef enum logic [4:0] {
        S_IDLE, S_LMUL, S_LWR, S_PAD, S_BAD, S_BRD, S_BM0, S_BM1, S_BM2,
        S_BM3, S_BM4, S_BWA, S_BWB, S_RRD, S_RM0, S_RM1, S_RSUM
    } t_state;

    // ---------------- elaboration-time ROM contents ----------------
    function automatic longint trig(input longint k, input bit use_win,
                                    input bit want_sin);
        longint unsigned t, x, x2, term;
        longint cs, sn, ca, sa;
        int q;
        t = 64'd4 * k;
        if (use_win) begin
            q = int'((t / NWIN) & 64'd3);
            x = (HALF_PI_Q30 * (t % NWIN)) / NWIN;
        end else begin
            q = int'((t / NTW) & 64'd3);
            x = (HALF_PI_Q30 * (t % NTW)) / NTW;
        end
        x2 = (x * x) >> 30;
        cs = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / C_COS_DIV[n-1];
            cs = (n % 2 == 1) ? cs - longint'(term) : cs + longint'(term);
        end
        sn = longint'(x);
        term = x;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / C_SIN_DIV[n-1];
            sn = (n % 2 == 1) ? sn - longint'(term) : sn + longint'(term);
        end
        case (q)
            0: begin ca = cs;  sa = sn;  end
            1: begin ca = -sn; sa = cs;  end
            2: begin ca = -cs; sa = -sn; end
            default: begin ca = sn; sa = -cs; end
        endcase
        return want_sin ? sa : ca;
    endfunction

    function automatic logic [ROM_W-1:0] win_val(input longint i);
        longint v;
        v = round_shift(ONE_Q30 - trig(i, 1'b1, 1'b0), 16);
        return v[ROM_W-1:0];
    endfunction

    function automatic logic [ROM_W-1:0] twr_val(input longint i);
        longint v;
        v = round_shift(trig(i, 1'b0, 1'b0), 15);
        return v[ROM_W-1:0];
    endfunction

    function automatic logic [ROM_W-1:0] twi_val(input longint i);
        longint v;
        v = -round_shift(trig(i, 1'b0, 1'b1), 15);
        return v[ROM_W-1:0];
    endfunction

    function automatic logic signed [39:0] rnd15(input logic signed [PW:0] v);
        logic signed [PW:0] t;
        t = v + (PW+1)'(16384);
        return t[PW:15];
    endfunction

    function automatic logic signed [STORE_W-1:0] sat27(input logic signed [40:0] v);
        if (v > 41'(STORE_MAX)) return STORE_MAX;
        if (v < 41'(STORE_MIN)) return STORE_MIN;
        return v[STORE_W-1:0];
    endfunction

    logic [ROM_W-1:0] win_rom [FFT_SIZE];
    logic [ROM_W-1:0] twr_rom [HALF];
    logic [ROM_W-1:0] twi_rom [HALF];

    for (genvar gi = 0; gi < FFT_SIZE; gi++) begin : g_win
        localparam logic [ROM_W-1:0] C_WIN = win_val(gi);
        assign win_rom[gi] = C_WIN;
    end
    for (genvar gi = 0; gi < HALF; gi++) begin : g_tw
        localparam logic [ROM_W-1:0] C_TWR = twr_val(gi);
        localparam logic [ROM_W-1:0] C_TWI = twi_val(gi);
        assign twr_rom[gi] = C_TWR;
        assign twi_rom[gi] = C_TWI;
    end

    // ---------------- registers ----------------
    t_state                     r_state;
    logic [AW:0]                r_cnt;
    logic                       r_valid;
    logic                       r_last;
    logic signed [SMP_W-1:0]    r_smp;
    logic [SW-1:0]              r_stage;
    logic [AW-2:0]              r_bc;
    logic [AW-1:0]              r_ra, r_rb;
    logic [AW-2:0]              r_k;
    logic [DW-1:0]              r_rda, r_rdb;
    logic [ROM_W-1:0]           r_win, r_twr, r_twi;
    logic signed [PW-1:0]       r_p, r_acc;
    logic signed [STORE_W-1:0]  r_ur, r_ui;
    logic signed [39:0]         r_vr, r_vi;
    logic [ERR_W-1:0]           r_rerr;
    logic                       r_out_v;
    logic [POWER_W-1:0]         r_pow;
    logic [ERR_W-1:0]           r_err;

    logic [DW-1:0] mem [FFT_SIZE];

    // ---------------- combinational ----------------
    logic                       w_accept;
    logic signed [STORE_W-1:0]  w_ma, w_mb;
    logic signed [PW-1:0]       w_prod;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [DW-1:0]              w_wdata;
    logic [AW-1:0]              w_brev;
    logic [AW-1:0]              w_mask;
    logic [AW-1:0]              w_bcx;
    logic [AW-1:0]              w_ia;
    logic [SW-1:0]              w_sh;
    logic [AW-1:0]              w_kx;
    logic [AW+BIN_W-1:0]        w_binx;
    logic                       w_bin_bad;
    logic signed [PW:0]         w_sum;
    logic [PW:0]                w_psum;
    logic signed [STORE_W-1:0]  w_xr, w_xi, w_wr, w_wi;
    logic signed [40:0]         w_ar, w_ai, w_br, w_bi;
    logic signed [39:0]         w_ld;
    logic                       w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_v || i_m_tready;

    assign w_xr = r_rdb[STORE_W-1:0];
    assign w_xi = r_rdb[DW-1:STORE_W];
    assign w_wr = STORE_W'(signed'(r_twr));
    assign w_wi = STORE_W'(signed'(r_twi));

    always_comb begin
        for (int b = 0; b < AW; b++) w_brev[AW-1-b] = r_cnt[b];
    end

    // butterfly indices: insert a zero at bit position stage of the counter
    assign w_mask = AW'((1 << r_stage) - 1);
    assign w_bcx  = {1'b0, r_bc};
    assign w_ia   = ((w_bcx & ~w_mask) << 1) | (w_bcx & w_mask);
    assign w_sh   = SW'(AW - 1) - r_stage;
    assign w_kx   = (w_bcx & w_mask) << w_sh;

    assign w_binx    = {{AW{1'b0}}, i_s_tdata[SMP_W +: BIN_W]};
    assign w_bin_bad = (32'(i_s_tdata[SMP_W +: BIN_W]) > 32'(HALF));

    // shared multiplier operand select
    always_comb begin
        w_ma = w_xr;
        w_mb = w_wr;
        case (r_state)
            S_LMUL: begin
                w_ma = STORE_W'(r_smp);
                w_mb = STORE_W'(signed'({1'b0, r_win}));
            end
            S_BM0: begin w_ma = w_xr; w_mb = w_wr; end
            S_BM1: begin w_ma = w_xi; w_mb = w_wi; end
            S_BM2: begin w_ma = w_xr; w_mb = w_wi; end
            S_BM3: begin w_ma = w_xi; w_mb = w_wr; end
            S_RM0: begin
                w_ma = r_rda[STORE_W-1:0];
                w_mb = r_rda[STORE_W-1:0];
            end
            S_RM1: begin
                w_ma = r_rda[DW-1:STORE_W];
                w_mb = r_rda[DW-1:STORE_W];
            end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_sum  = (r_state == S_BM2) ? (PW+1)'(r_acc) - (PW+1)'(r_p)
                                       : (PW+1)'(r_acc) + (PW+1)'(r_p);
    assign w_psum = unsigned'(w_sum);

    assign w_ar = 41'(r_ur) + 41'(r_vr);
    assign w_ai = 41'(r_ui) + 41'(r_vi);
    assign w_br = 41'(r_ur) - 41'(r_vr);
    assign w_bi = 41'(r_ui) - 41'(r_vi);

    assign w_ld = rnd15((PW+1)'(r_p));

    // memory write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_brev;
        w_wdata = '0;
        case (r_state)
            S_LWR: begin
                w_we = 1'b1;
                w_wdata = {{STORE_W{1'b0}}, w_ld[STORE_W-1:0]};
            end
            S_PAD: w_we = !r_cnt[AW];
            S_BWA: begin
                w_we = 1'b1;
                w_waddr = r_ra;
                w_wdata = {sat27(w_ai), sat27(w_ar)};
            end
            S_BWB: begin
                w_we = 1'b1;
                w_waddr = r_rb;
                w_wdata = {sat27(w_bi), sat27(w_br)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rda <= mem[r_ra];
        r_rdb <= mem[r_rb];
        r_win <= win_rom[r_cnt[AW-1:0]];
        r_twr <= twr_rom[r_k];
        r_twi <= twi_rom[r_k];
        // the second square stays put while the sum waits for the output
        if (r_state != S_RSUM) r_p <= w_prod;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_m_tready && r_state != S_RSUM) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_s_tuser) begin
                            r_smp  <= i_s_tdata[SMP_W-1:0];
                            r_last <= i_s_tlast;
                            if (r_cnt == '0) r_valid <= 1'b0;
                            if (!r_cnt[AW])   r_state <= S_LMUL;
                            else if (i_s_tlast) r_state <= S_PAD;
                        end else begin
                            r_ra <= w_binx[AW-1:0];
                            if (w_bin_bad) begin
                                r_rerr  <= ERR_RANGE;
                                r_state <= S_RSUM;
                            end else if (!r_valid) begin
                                r_rerr  <= ERR_EMPTY;
                                r_state <= S_RSUM;
                            end else begin
                                r_rerr  <= ERR_OK;
                                r_state <= S_RRD;
                            end
                        end
                    end
                end
                S_LMUL: r_state <= S_LWR;
                S_LWR: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= r_last ? S_PAD : S_IDLE;
                end
                S_PAD: begin
                    if (r_cnt[AW]) begin
                        r_stage <= '0;
                        r_bc    <= '0;
                        r_state <= S_BAD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_BAD: begin
                    r_ra    <= w_ia;
                    r_rb    <= w_ia | AW'(1 << r_stage);
                    r_k     <= w_kx[AW-2:0];
                    r_state <= S_BRD;
                end
                S_BRD: r_state <= S_BM0;
                S_BM0: begin
                    r_ur    <= r_rda[STORE_W-1:0];
                    r_ui    <= r_rda[DW-1:STORE_W];
                    r_state <= S_BM1;
                end
                S_BM1: begin r_acc <= r_p; r_state <= S_BM2; end
                S_BM2: begin r_vr <= rnd15(w_sum); r_state <= S_BM3; end
                S_BM3: begin r_acc <= r_p; r_state <= S_BM4; end
                S_BM4: begin r_vi <= rnd15(w_sum); r_state <= S_BWA; end
                S_BWA: r_state <= S_BWB;
                S_BWB: begin
                    r_bc <= r_bc + 1'b1;
                    if (&r_bc) begin
                        if (r_stage == SW'(AW - 1)) begin
                            r_valid <= 1'b1;
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_stage <= r_stage + 1'b1;
                            r_state <= S_BAD;
                        end
                    end else begin
                        r_state <= S_BAD;
                    end
                end
                S_RRD: r_state <= S_RM0;
                S_RM0: r_state <= S_RM1;
                S_RM1: begin r_acc <= r_p; r_state <= S_RSUM; end
                S_RSUM: begin
                    if (w_out_free) begin
                        r_out_v <= 1'b1;
                        r_err   <= r_rerr;
                        if (r_rerr != ERR_OK)
                            r_pow <= '0;
                        else if (w_psum > (PW+1)'(POWER_MAX))
                            r_pow <= POWER_MAX;
                        else
                            r_pow <= w_psum[POWER_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {3'b000, r_err, r_pow};

    // ---------------- assertions ----------------
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("sample memory written while idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(FFT_SIZE))
        else $error("load count beyond frame size");

    a_ok_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_m_tvalid) && r_err == ERR_OK) |-> r_valid)
        else $error("ok result without finished spectrum");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWB) |=> !o_s_tready || r_valid)
        else $error("transform ended without valid spectrum");

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for hann_fft_power_spectrum. Drives load and read
// transactions, predicts window/FFT/power results internally. Uses hfps_pkg.
`timescale 1ns / 1ps

module tb;
    import hfps_pkg::*;

    localparam int  N          = 1024;
    localparam int  LOG2N      = 10;
    localparam bit  MODE_LOAD  = 1'b0;
    localparam bit  MODE_READ  = 1'b1;
    localparam int  STALL_LIMIT = 250000;

    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic [ERR_W-1:0]   err;
    } t_bin_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [15:0] sample, [25:16] bin
    logic        i_s_tuser = 1'b0; // mode
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;        // [50:0] power, [52:51] error

    hann_fft_power_spectrum #(.FFT_SIZE(N)) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint     hann_q15 [N];
    longint     twid_re [N/2];
    longint     twid_im [N/2];
    longint     pt_re [N];
    longint     pt_im [N];
    int         frame_fill;
    bit         spectrum_ok;
    t_bin_reply pending_bins [$];

    int  fail_count = 0;
    int  snd_idle = 0;
    int  rcv_idle = 0;
    int  reads_done = 0;
    int  frames_done = 0;
    int  quiet_cycles = 0;

    function automatic longint rnd_shr(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip27(longint v);
        if (v > 64'sd67108863) return 64'sd67108863;
        if (v < -64'sd67108864) return -64'sd67108864;
        return v;
    endfunction

    // cos/sin of 2*pi*k/m with 30-bit fraction, quadrant-folded series
    task automatic cos_sin_q30(input int unsigned k, input int unsigned m,
                               output longint c, output longint s);
        longint unsigned t, x, x2, term;
        longint cs, sn;
        int unsigned q;
        t = 4 * longint'(k);
        q = (t / m) & 3;
        x = (HALF_PI_Q30 * (t % m)) / m;
        x2 = (x * x) >> 30;
        cs = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
            cs = (n & 1) ? cs - longint'(term) : cs + longint'(term);
        end
        sn = longint'(x);
        term = x;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            sn = (n & 1) ? sn - longint'(term) : sn + longint'(term);
        end
        case (q)
            0: begin c = cs;  s = sn;  end
            1: begin c = -sn; s = cs;  end
            2: begin c = -cs; s = -sn; end
            default: begin c = sn; s = -cs; end
        endcase
    endtask

    task automatic build_tables();
        longint c, s;
        for (int i = 0; i < N; i++) begin
            cos_sin_q30(i, N - 1, c, s);
            hann_q15[i] = rnd_shr(ONE_Q30 - c, 16);
        end
        for (int i = 0; i < N / 2; i++) begin
            cos_sin_q30(i, N, c, s);
            twid_re[i] = rnd_shr(c, 15);
            twid_im[i] = -rnd_shr(s, 15);
        end
    endtask

    task automatic transform_frame();
        int r;
        longint tr, ti, vr, vi, ur, ui;
        for (int i = 0; i < N; i++) begin
            r = 0;
            for (int j = 0; j < LOG2N; j++) r |= ((i >> j) & 1) << (LOG2N - 1 - j);
            if (i < r) begin
                tr = pt_re[i]; ti = pt_im[i];
                pt_re[i] = pt_re[r]; pt_im[i] = pt_im[r];
                pt_re[r] = tr; pt_im[r] = ti;
            end
        end
        for (int len = 2; len <= N; len <<= 1) begin
            for (int base = 0; base < N; base += len) begin
                for (int j = 0; j < len / 2; j++) begin
                    int ia, ib, k;
                    ia = base + j;
                    ib = ia + len / 2;
                    k = (j * (N / len)) & (N / 2 - 1);
                    vr = rnd_shr(pt_re[ib] * twid_re[k] - pt_im[ib] * twid_im[k], 15);
                    vi = rnd_shr(pt_re[ib] * twid_im[k] + pt_im[ib] * twid_re[k], 15);
                    ur = pt_re[ia]; ui = pt_im[ia];
                    pt_re[ia] = clip27(ur + vr); pt_im[ia] = clip27(ui + vi);
                    pt_re[ib] = clip27(ur - vr); pt_im[ib] = clip27(ui - vi);
                end
            end
        end
    endtask

    task automatic predict_item(bit mode, logic signed [15:0] smp, bit lst, logic [9:0] bn);
        t_bin_reply rep;
        longint unsigned pw;
        if (mode == MODE_LOAD) begin
            if (frame_fill == 0) spectrum_ok = 1'b0;
            if (frame_fill < N) begin
                pt_re[frame_fill] = rnd_shr(longint'(smp) * hann_q15[frame_fill], 15);
                pt_im[frame_fill] = 0;
                frame_fill++;
            end
            if (lst) begin
                for (int i = frame_fill; i < N; i++) begin
                    pt_re[i] = 0; pt_im[i] = 0;
                end
                transform_frame();
                spectrum_ok = 1'b1;
                frame_fill = 0;
                frames_done++;
            end
        end else begin
            rep.power = '0;
            if (bn > N / 2) rep.err = ERR_RANGE;
            else if (!spectrum_ok) rep.err = ERR_EMPTY;
            else begin
                rep.err = ERR_OK;
                pw = longint'(pt_re[bn] * pt_re[bn]) + longint'(pt_im[bn] * pt_im[bn]);
                rep.power = (pw > POWER_MAX) ? POWER_MAX : pw[POWER_W-1:0];
            end
            pending_bins = {pending_bins, rep};
            reads_done++;
        end
    endtask

    // entered and left at a falling edge
    task automatic send_item(bit mode, logic [15:0] smp, bit lst, logic [9:0] bn);
        while ($urandom_range(99) < snd_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = mode;
        i_s_tlast = lst;
        i_s_tdata = {6'd0, bn, smp};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(mode, smp, lst, bn);
        @(negedge i_clk);
    endtask

    task automatic load(logic [15:0] smp, bit lst);
        send_item(MODE_LOAD, smp, lst, 10'($urandom));
    endtask

    task automatic read_bin(logic [9:0] bn);
        send_item(MODE_READ, 16'($urandom), 1'($urandom), bn);
    endtask

    always @(negedge i_clk)
        if (i_rst_n) i_m_tready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected result power=%0d err=%0d", $time,
                         o_m_tdata[50:0], o_m_tdata[52:51]);
                fail_count++;
            end else begin
                t_bin_reply want;
                want = pending_bins.pop_front();
                if (o_m_tdata[50:0] !== want.power || o_m_tdata[52:51] !== want.err) begin
                    $display("%0t: mismatch expected power=%0d err=%0d actual power=%0d err=%0d",
                             $time, want.power, want.err, o_m_tdata[50:0], o_m_tdata[52:51]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_bins.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_reads_without_spectrum();
        read_bin(10'd0);
        read_bin(10'd512);
        read_bin(10'd513);
        read_bin(10'd1023);
    endtask

    task automatic test_extreme_samples();
        load(16'h7fff, 1'b0);
        load(16'h8000, 1'b0);
        load(16'h0000, 1'b0);
        load(16'hffff, 1'b0);
        load(16'h7fff, 1'b1);
        read_bin(10'd0);
        read_bin(10'd1);
        read_bin(10'd512);
        read_bin(10'd513);
    endtask

    // one-sample frame, then a new frame start drops the spectrum
    task automatic test_frame_restart();
        load(16'h4000, 1'b1);
        read_bin(10'd0);
        load(16'h8000, 1'b0);
        read_bin(10'd3);
        load(16'h1234, 1'b1);
        read_bin(10'd2);
    endtask

    // loads past N are dropped; the last mark on one still runs the transform
    task automatic test_overlong_frame();
        for (int i = 0; i < N + 2; i++)
            load((i & 1) ? 16'h8000 : 16'h7fff, i == N + 1);
        read_bin(10'd0);
        read_bin(10'd256);
        read_bin(10'd512);
    endtask

    task automatic test_random_frames(int frames);
        int nload;
        for (int f = 0; f < frames; f++) begin
            nload = $urandom_range(24, 1);
            for (int i = 0; i < nload; i++) begin
                if ($urandom_range(15) == 0) read_bin(10'($urandom));
                load(16'($urandom), i == nload - 1);
            end
            repeat ($urandom_range(16, 8))
                read_bin(($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(N / 2)));
        end
    endtask

    initial begin
        build_tables();
        frame_fill = 0;
        spectrum_ok = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reads_without_spectrum();
        test_extreme_samples();
        test_frame_restart();
        test_overlong_frame();

        snd_idle = 34; rcv_idle = 68;
        test_random_frames(2);
        snd_idle = 68; rcv_idle = 34;
        test_random_frames(2);
        snd_idle = 0;  rcv_idle = 0;
        test_random_frames(2);
        i_s_tvalid = 1'b0;

        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d frames and %0d bin reads, including empty, out-of-range",
                 frames_done, reads_done);
        $display("and overlong-frame cases under sender and receiver stalls.");
        if (fail_count == 0 && pending_bins.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/hfps_pkg.sv
src/hann_fft_power_spectrum.sv
dv/tb.sv
